/* hw/rtl/aar_pkg.sv */
package aar_pkg;

   localparam int COEF_FRAC_BITS_DEFAULT = 14;
   localparam int CORDIC_STEPS_DEFAULT = 16;

   localparam int QW = 34;
   localparam int SQRT_STEPS = 31;
   localparam int DIV_STEPS = 32;
   localparam int NORM_LAT = SQRT_STEPS + DIV_STEPS + 4;

   localparam logic signed [QW-1:0] ONE_Q30 = 34'sd1073741824;
   localparam logic signed [QW-1:0] GAIN_Q30 = 34'sd652032874;

   typedef enum logic [1:0] {
      MODE_AXIS = 2'd0,
      MODE_X    = 2'd1,
      MODE_Y    = 2'd2,
      MODE_Z    = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type           mode;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
      logic [15:0]        angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] r0c0;
      logic signed [15:0] r0c1;
      logic signed [15:0] r0c2;
      logic signed [15:0] r1c0;
      logic signed [15:0] r1c1;
      logic signed [15:0] r1c2;
      logic signed [15:0] r2c0;
      logic signed [15:0] r2c1;
      logic signed [15:0] r2c2;
      logic               degenerate;
   } rsp_type;

   function automatic logic signed [QW-1:0] atan_turn(input int idx);
      logic signed [QW-1:0] v;
      unique case (idx)
         0: v = 34'sd536870912;
         1: v = 34'sd316933406;
         2: v = 34'sd167458907;
         3: v = 34'sd85004756;
         4: v = 34'sd42667331;
         5: v = 34'sd21354465;
         6: v = 34'sd10679838;
         7: v = 34'sd5340245;
         8: v = 34'sd2670163;
         9: v = 34'sd1335087;
         10: v = 34'sd667544;
         11: v = 34'sd333772;
         12: v = 34'sd166886;
         13: v = 34'sd83443;
         14: v = 34'sd41722;
         15: v = 34'sd20861;
         16: v = 34'sd10430;
         17: v = 34'sd5215;
         18: v = 34'sd2608;
         19: v = 34'sd1304;
         20: v = 34'sd652;
         21: v = 34'sd326;
         22: v = 34'sd163;
         23: v = 34'sd81;
         24: v = 34'sd41;
         25: v = 34'sd20;
         26: v = 34'sd10;
         27: v = 34'sd5;
         28: v = 34'sd3;
         29: v = 34'sd1;
         30: v = 34'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Q30 product with rounding toward the nearest, ties upward.
   function automatic logic signed [QW-1:0] mulq(input logic signed [QW-1:0] a,
                                                 input logic signed [QW-1:0] b);
      logic signed [2*QW-1:0] p;
      logic signed [2*QW-1:0] r;
      p = a * b;
      r = (p + (2*QW)'(64'sd536870912)) >>> 30;
      return r[QW-1:0];
   endfunction

endpackage

/* hw/rtl/aar_cordic.sv */
module aar_cordic import aar_pkg::*; #(
   parameter int STEPS = CORDIC_STEPS_DEFAULT
) (
   input  logic                 clock,
   input  logic [15:0]          angle,
   output logic signed [QW-1:0] sin_out,
   output logic signed [QW-1:0] cos_out
);

   localparam int NSTEP = (STEPS > 32) ? 32 : STEPS;

   logic [15:0] sum_in;
   logic [1:0]  quad_in;
   logic [15:0] resid_in;

   logic signed [QW-1:0] x_ff [0:NSTEP];
   logic signed [QW-1:0] y_ff [0:NSTEP];
   logic signed [QW-1:0] z_ff [0:NSTEP];
   logic [1:0]           quad_ff [0:NSTEP];
   logic signed [QW-1:0] sin_ff;
   logic signed [QW-1:0] cos_ff;

   assign sum_in = angle + 16'd8192;
   assign quad_in = sum_in[15:14];
   assign resid_in = angle - {quad_in, 14'd0};

   always_ff @(posedge clock) begin
      x_ff[0] <= GAIN_Q30;
      y_ff[0] <= '0;
      z_ff[0] <= {{(QW-32){resid_in[15]}}, resid_in, 16'd0};
      quad_ff[0] <= quad_in;
   end

   for (genvar i = 0; i < NSTEP; i++) begin : g_step
      logic signed [QW-1:0] dx;
      logic signed [QW-1:0] dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (!z_ff[i][QW-1]) begin
            x_ff[i+1] <= x_ff[i] - dx;
            y_ff[i+1] <= y_ff[i] + dy;
            z_ff[i+1] <= z_ff[i] - atan_turn(i);
         end else begin
            x_ff[i+1] <= x_ff[i] + dx;
            y_ff[i+1] <= y_ff[i] - dy;
            z_ff[i+1] <= z_ff[i] + atan_turn(i);
         end
         quad_ff[i+1] <= quad_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      unique case (quad_ff[NSTEP])
         2'd0: begin
            cos_ff <= x_ff[NSTEP];
            sin_ff <= y_ff[NSTEP];
         end
         2'd1: begin
            cos_ff <= -y_ff[NSTEP];
            sin_ff <= x_ff[NSTEP];
         end
         2'd2: begin
            cos_ff <= -x_ff[NSTEP];
            sin_ff <= -y_ff[NSTEP];
         end
         default: begin
            cos_ff <= y_ff[NSTEP];
            sin_ff <= -x_ff[NSTEP];
         end
      endcase
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

/* hw/rtl/aar_norm.sv */
module aar_norm import aar_pkg::*; (
   input  logic                 clock,
   input  logic signed [15:0]   axis_x,
   input  logic signed [15:0]   axis_y,
   input  logic signed [15:0]   axis_z,
   output logic signed [QW-1:0] unit_x,
   output logic signed [QW-1:0] unit_y,
   output logic signed [QW-1:0] unit_z
);

   logic signed [15:0] ax [3];
   logic [31:0] sq_ff [3];
   logic [15:0] mag1_ff [3];
   logic        neg1_ff [3];
   logic [31:0] len2_ff [0:SQRT_STEPS];
   logic [33:0] rem_ff [0:SQRT_STEPS];
   logic [30:0] root_ff [0:SQRT_STEPS];
   logic [15:0] smag_ff [3][0:SQRT_STEPS];
   logic        sneg_ff [3][0:SQRT_STEPS];
   logic [30:0] dl_ff [0:DIV_STEPS];
   logic [60:0] dn_ff [3][0:DIV_STEPS];
   logic [31:0] dr_ff [3][0:DIV_STEPS];
   logic [31:0] dq_ff [3][0:DIV_STEPS];
   logic        dneg_ff [3][0:DIV_STEPS];
   logic signed [QW-1:0] unit_ff [3];

   assign ax[0] = axis_x;
   assign ax[1] = axis_y;
   assign ax[2] = axis_z;

   for (genvar c = 0; c < 3; c++) begin : g_comp
      logic signed [31:0] sq_in;
      logic [60:0]        n_in;
      assign sq_in = ax[c] * ax[c];
      assign n_in = {smag_ff[c][SQRT_STEPS], 45'd0} + {31'd0, root_ff[SQRT_STEPS][30:1]};

      always_ff @(posedge clock) begin
         sq_ff[c] <= sq_in;
         mag1_ff[c] <= ax[c][15] ? 16'(-ax[c]) : ax[c];
         neg1_ff[c] <= ax[c][15];
         smag_ff[c][0] <= mag1_ff[c];
         sneg_ff[c][0] <= neg1_ff[c];
         dn_ff[c][0] <= n_in;
         dr_ff[c][0] <= {3'd0, n_in[60:32]};
         dq_ff[c][0] <= '0;
         dneg_ff[c][0] <= sneg_ff[c][SQRT_STEPS];
         unit_ff[c] <= dneg_ff[c][DIV_STEPS] ? -QW'(dq_ff[c][DIV_STEPS])
                                             : QW'(dq_ff[c][DIV_STEPS]);
      end

      for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_carry
         always_ff @(posedge clock) begin
            smag_ff[c][k+1] <= smag_ff[c][k];
            sneg_ff[c][k+1] <= sneg_ff[c][k];
         end
      end

      for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
         logic [32:0] r2;
         logic        ge;
         logic [32:0] diff;
         assign r2 = {dr_ff[c][j], dn_ff[c][j][DIV_STEPS-1-j]};
         assign diff = r2 - {2'd0, dl_ff[j]};
         assign ge = r2 >= {2'd0, dl_ff[j]};
         always_ff @(posedge clock) begin
            dn_ff[c][j+1] <= dn_ff[c][j];
            dr_ff[c][j+1] <= ge ? diff[31:0] : r2[31:0];
            dq_ff[c][j+1] <= {dq_ff[c][j][30:0], ge};
            dneg_ff[c][j+1] <= dneg_ff[c][j];
         end
      end
   end

   always_ff @(posedge clock) begin
      len2_ff[0] <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      rem_ff[0] <= '0;
      root_ff[0] <= '0;
      dl_ff[0] <= root_ff[SQRT_STEPS];
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      logic [61:0] v;
      logic [35:0] rem2;
      logic [35:0] trial;
      logic        ge;
      assign v = {len2_ff[k], 30'd0};
      assign rem2 = {rem_ff[k], v[2*(SQRT_STEPS-1-k)+1 -: 2]};
      assign trial = {3'd0, root_ff[k], 2'b01};
      assign ge = rem2 >= trial;
      always_ff @(posedge clock) begin
         len2_ff[k+1] <= len2_ff[k];
         rem_ff[k+1] <= ge ? 34'(rem2 - trial) : rem2[33:0];
         root_ff[k+1] <= {root_ff[k][29:0], ge};
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_lcarry
      always_ff @(posedge clock) begin
         dl_ff[j+1] <= dl_ff[j];
      end
   end

   assign unit_x = unit_ff[0];
   assign unit_y = unit_ff[1];
   assign unit_z = unit_ff[2];

endmodule

/* hw/rtl/axis_angle_rotation_matrix.sv */
// Rotation matrix unit: one item enters per clock cycle whenever start is high, and
// busy never rises. Each item's matrix leaves after the axis normalization and the
// registers p1 to p4, marked by rsp_strobe for one cycle; the receiver cannot stall.
// The latency is set by the axis normalization: a square root pipeline with one root
// bit per stage, followed by three parallel dividers with one quotient bit per stage.
module axis_angle_rotation_matrix import aar_pkg::*; #(
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEFAULT,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int CORDIC_LAT = ((CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS) + 2;
   localparam int SC_DELAY = NORM_LAT - CORDIC_LAT;
   localparam int SH = 30 - COEF_FRAC_BITS;
   localparam logic signed [QW:0] RND =
      (SH > 0) ? ((QW+1)'(1) << ((SH > 0) ? SH - 1 : 0)) : '0;
   localparam logic signed [QW:0] SAT_HI = 35'sd32767;
   localparam logic signed [QW:0] SAT_LO = -35'sd32768;

   logic signed [QW-1:0] sin_w, cos_w;
   logic signed [QW-1:0] ux_w, uy_w, uz_w;
   logic                 degen_in;

   logic     vld_ff [0:NORM_LAT-1];
   mode_type mode_ff [0:NORM_LAT-1];
   logic     degen_ff [0:NORM_LAT-1];
   logic signed [QW-1:0] sd_ff [0:SC_DELAY-1];
   logic signed [QW-1:0] cd_ff [0:SC_DELAY-1];

   logic                 p1_vld_ff, p2_vld_ff, p3_vld_ff, p4_vld_ff;
   mode_type             p1_mode_ff, p2_mode_ff;
   logic                 p1_degen_ff, p2_degen_ff, p3_degen_ff;
   logic signed [QW-1:0] p1_u_ff [3];
   logic signed [QW-1:0] p1_pp_ff [6];
   logic signed [QW-1:0] p1_t_ff, p1_s_ff, p1_c_ff;
   logic signed [QW-1:0] p2_tp_ff [6];
   logic signed [QW-1:0] p2_us_ff [3];
   logic signed [QW-1:0] p2_s_ff, p2_c_ff;
   logic signed [QW-1:0] m_in [9];
   logic signed [QW-1:0] m_ff [9];
   logic signed [15:0]   coef_in [9];
   rsp_type              rsp_ff;

   assign busy = 1'b0;
   assign degen_in = (req_data.mode == MODE_AXIS) && (req_data.axis_x == 16'sd0)
                     && (req_data.axis_y == 16'sd0) && (req_data.axis_z == 16'sd0);

   aar_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .angle   (req_data.angle),
      .sin_out (sin_w),
      .cos_out (cos_w)
   );

   aar_norm u_norm (
      .clock  (clock),
      .axis_x (req_data.axis_x),
      .axis_y (req_data.axis_y),
      .axis_z (req_data.axis_z),
      .unit_x (ux_w),
      .unit_y (uy_w),
      .unit_z (uz_w)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= start;
      end
      mode_ff[0] <= req_data.mode;
      degen_ff[0] <= degen_in;
      sd_ff[0] <= sin_w;
      cd_ff[0] <= cos_w;
   end

   for (genvar k = 1; k < NORM_LAT; k++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_ff[k-1];
         end
         mode_ff[k] <= mode_ff[k-1];
         degen_ff[k] <= degen_ff[k-1];
      end
   end

   for (genvar k = 1; k < SC_DELAY; k++) begin : g_sc
      always_ff @(posedge clock) begin
         sd_ff[k] <= sd_ff[k-1];
         cd_ff[k] <= cd_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= vld_ff[NORM_LAT-1];
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
      end
      p1_mode_ff <= mode_ff[NORM_LAT-1];
      p1_degen_ff <= degen_ff[NORM_LAT-1];
      p1_u_ff[0] <= ux_w;
      p1_u_ff[1] <= uy_w;
      p1_u_ff[2] <= uz_w;
      p1_pp_ff[0] <= mulq(ux_w, ux_w);
      p1_pp_ff[1] <= mulq(uy_w, uy_w);
      p1_pp_ff[2] <= mulq(uz_w, uz_w);
      p1_pp_ff[3] <= mulq(ux_w, uy_w);
      p1_pp_ff[4] <= mulq(uy_w, uz_w);
      p1_pp_ff[5] <= mulq(uz_w, ux_w);
      p1_t_ff <= ONE_Q30 - cd_ff[SC_DELAY-1];
      p1_s_ff <= sd_ff[SC_DELAY-1];
      p1_c_ff <= cd_ff[SC_DELAY-1];

      p2_mode_ff <= p1_mode_ff;
      p2_degen_ff <= p1_degen_ff;
      for (int i = 0; i < 6; i++) begin
         p2_tp_ff[i] <= mulq(p1_t_ff, p1_pp_ff[i]);
      end
      for (int i = 0; i < 3; i++) begin
         p2_us_ff[i] <= mulq(p1_u_ff[i], p1_s_ff);
      end
      p2_s_ff <= p1_s_ff;
      p2_c_ff <= p1_c_ff;

      p3_degen_ff <= p2_degen_ff;
      for (int i = 0; i < 9; i++) begin
         m_ff[i] <= m_in[i];
      end

      rsp_ff.r0c0 <= coef_in[0];
      rsp_ff.r0c1 <= coef_in[1];
      rsp_ff.r0c2 <= coef_in[2];
      rsp_ff.r1c0 <= coef_in[3];
      rsp_ff.r1c1 <= coef_in[4];
      rsp_ff.r1c2 <= coef_in[5];
      rsp_ff.r2c0 <= coef_in[6];
      rsp_ff.r2c1 <= coef_in[7];
      rsp_ff.r2c2 <= coef_in[8];
      rsp_ff.degenerate <= p3_degen_ff;
   end

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         m_in[i] = '0;
      end
      unique case (p2_mode_ff)
         MODE_AXIS: begin
            if (!p2_degen_ff) begin
               m_in[0] = p2_tp_ff[0] + p2_c_ff;
               m_in[1] = p2_tp_ff[3] - p2_us_ff[2];
               m_in[2] = p2_tp_ff[5] + p2_us_ff[1];
               m_in[3] = p2_tp_ff[3] + p2_us_ff[2];
               m_in[4] = p2_tp_ff[1] + p2_c_ff;
               m_in[5] = p2_tp_ff[4] - p2_us_ff[0];
               m_in[6] = p2_tp_ff[5] - p2_us_ff[1];
               m_in[7] = p2_tp_ff[4] + p2_us_ff[0];
               m_in[8] = p2_tp_ff[2] + p2_c_ff;
            end
         end
         MODE_X: begin
            m_in[0] = ONE_Q30;
            m_in[4] = p2_c_ff;
            m_in[5] = -p2_s_ff;
            m_in[7] = p2_s_ff;
            m_in[8] = p2_c_ff;
         end
         MODE_Y: begin
            m_in[0] = p2_c_ff;
            m_in[2] = p2_s_ff;
            m_in[4] = ONE_Q30;
            m_in[6] = -p2_s_ff;
            m_in[8] = p2_c_ff;
         end
         default: begin
            m_in[0] = p2_c_ff;
            m_in[1] = -p2_s_ff;
            m_in[3] = p2_s_ff;
            m_in[4] = p2_c_ff;
            m_in[8] = ONE_Q30;
         end
      endcase
   end

   for (genvar i = 0; i < 9; i++) begin : g_coef
      logic signed [QW:0] rounded;
      logic signed [QW:0] shifted;
      assign rounded = {m_ff[i][QW-1], m_ff[i]} + RND;
      assign shifted = rounded >>> SH;
      always_comb begin
         if (shifted > SAT_HI) begin
            coef_in[i] = 16'sh7fff;
         end else if (shifted < SAT_LO) begin
            coef_in[i] = -16'sh8000;
         end else begin
            coef_in[i] = shifted[15:0];
         end
      end
   end

   assign rsp_strobe = p4_vld_ff;
   assign rsp_data = rsp_ff;

endmodule
